// File: design/mbsgd_pkg.sv
package mbsgd_pkg;

  localparam int MAX_FEATURES = 16;
  localparam int MAX_BATCH    = 256;
  localparam int BIAS_INDEX   = 16;

  localparam int SAMPLE_W = 24;
  localparam int WEIGHT_W = 32;
  localparam int SUM_W    = 48;
  localparam int SQ_W     = 48;
  localparam int IDX_W    = 5;
  localparam int LR_W     = 16;
  localparam int FC_W     = 5;
  localparam int BC_W     = $clog2(MAX_BATCH + 1);
  localparam int NUM_W    = 48;

  typedef enum logic [1:0] {
    OP_FEATURE,
    OP_TRAIN,
    OP_EVAL,
    OP_LOAD
  } opcode_t;

  typedef enum logic {
    REG_STEP_RATE,
    REG_FEATURE_COUNT
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOT,
    ST_DOT_FIN,
    ST_PRED,
    ST_ERR,
    ST_SQ,
    ST_EMIT_PRED,
    ST_G_PRIME,
    ST_G_WALK,
    ST_G_END,
    ST_U_HEAD,
    ST_U_MUL,
    ST_U_SUM,
    ST_U_DIV,
    ST_U_APPLY,
    ST_U_EMIT
  } state_t;

  // one lane of the ring: buffered feature, weight and its running sum
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [WEIGHT_W-1:0] weight;
    logic signed [SUM_W-1:0]    gsum;
  } cell_t;

endpackage

// File: design/mbsgd_cell.sv
module mbsgd_cell (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  shift,
  input  logic                                  ld_sample,
  input  logic                                  ld_weight,
  input  logic signed [mbsgd_pkg::SAMPLE_W-1:0] load_value,
  input  mbsgd_pkg::cell_t                      din,
  output mbsgd_pkg::cell_t                      dout
);
  import mbsgd_pkg::*;

  logic signed [SAMPLE_W-1:0] sample;
  logic signed [WEIGHT_W-1:0] weight;
  logic signed [SUM_W-1:0]    gsum;

  always_ff @(posedge clk) begin
    if (shift) begin
      sample <= din.sample;
    end else if (ld_sample) begin
      sample <= load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
      gsum   <= '0;
    end else if (shift) begin
      weight <= din.weight;
      gsum   <= din.gsum;
    end else if (ld_weight) begin
      weight <= {{(WEIGHT_W - SAMPLE_W){load_value[SAMPLE_W-1]}}, load_value};
    end
  end

  assign dout.sample = sample;
  assign dout.weight = weight;
  assign dout.gsum   = gsum;

endmodule

// File: design/mbsgd_div.sv
module mbsgd_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [mbsgd_pkg::NUM_W-1:0]      num,
  input  logic [mbsgd_pkg::BC_W-1:0]       den,
  output logic                             busy,
  output logic                             done,
  output logic [mbsgd_pkg::NUM_W-1:0]      quot
);
  import mbsgd_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] quo;
  logic [BC_W-1:0]  rem;
  logic [CNT_W-1:0] cnt;
  logic [BC_W:0]    trial;
  logic [BC_W:0]    diff;
  logic             ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= num;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[NUM_W-2:0], ge};
        rem <= ge ? diff[BC_W-1:0] : trial[BC_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = quo;

endmodule

// File: design/minibatch_sgd_linear_regression.sv
// Feature, weight-load and target words alike are taken only while idle.
// Evaluation target: the prediction word follows a ring walk for the dot product.
// Training target: a second ring walk then adds to the per-weight sums.
// End of batch: each updated weight and then the bias pass through the 48-step serial
// divider; lanes beyond the feature count are skipped without a division.
// Reset (synchronous, active high) clears weights, bias, sums and count; rate 66, count 13.
module minibatch_sgd_linear_regression (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // sample_value [23:0], weight_index [28:24]
  input  logic [1:0]   s_axis_tuser,   // opcode
  input  logic         s_axis_tlast,   // end_of_batch
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,   // result_value [31:0], prediction_error [63:32],
                                       // squared_error [111:64], result_index [116:112]
  output logic         m_axis_tuser,   // result_kind
  output logic         m_axis_tlast,   // last_result
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);
  import mbsgd_pkg::*;

  localparam logic [IDX_W-1:0] LAST_HOP = IDX_W'(MAX_FEATURES - 1);
  localparam logic [IDX_W-1:0] BIAS_IDX = IDX_W'(BIAS_INDEX);

  function automatic logic signed [WEIGHT_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return v[WEIGHT_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sat48(input logic signed [63:0] v);
    if (v > 64'sh0000_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (v < -64'sh0000_8000_0000_0000) return 48'sh8000_0000_0000;
    return v[SUM_W-1:0];
  endfunction

  state_t state, state_next;

  logic [LR_W-1:0]            step_rate;
  logic [FC_W-1:0]            feature_count;
  logic [IDX_W-1:0]           lanes;
  logic [IDX_W-1:0]           feature_position;
  logic signed [WEIGHT_W-1:0] bias_value;
  logic signed [SUM_W-1:0]    bias_gsum;
  logic [BC_W-1:0]            batch_count;

  cell_t ring [MAX_FEATURES];
  cell_t tail_in;
  logic  shift;

  logic [IDX_W-1:0]           hop;
  opcode_t                    op;
  logic                       eob;
  logic signed [SAMPLE_W-1:0] target;
  logic signed [55:0]         prod;
  logic signed [60:0]         acc;
  logic signed [WEIGHT_W-1:0] pred;
  logic signed [WEIGHT_W-1:0] err;
  logic signed [63:0]         sq_raw;

  logic                       neg;
  logic [SUM_W-1:0]           mag;
  logic [39:0]                pp_hi;
  logic [39:0]                pp_lo;
  logic [63:0]                mag_sum;
  logic signed [WEIGHT_W-1:0] new_weight;
  logic                       div_start;
  logic                       div_busy;
  logic                       div_done;
  logic [NUM_W-1:0]           quot;
  logic [BC_W-1:0]            den;

  logic                       out_valid;
  logic                       out_kind;
  logic signed [WEIGHT_W-1:0] out_value;
  logic signed [WEIGHT_W-1:0] out_err;
  logic [SQ_W-1:0]            out_sq;
  logic [IDX_W-1:0]           out_index;
  logic                       out_last;
  logic                       out_free;

  logic                       in_fire;
  opcode_t                    in_op;
  logic signed [SAMPLE_W-1:0] in_val;
  logic [IDX_W-1:0]           in_idx;

  logic signed [SAMPLE_W-1:0] head_sample;
  logic signed [SAMPLE_W-1:0] next_sample;
  logic signed [WEIGHT_W-1:0] head_weight;
  logic signed [SUM_W-1:0]    head_gsum;
  logic signed [SUM_W-1:0]    src_sum;
  logic signed [WEIGHT_W-1:0] src_weight;
  logic signed [SUM_W-1:0]    gsum_new;
  logic                       head_active;
  logic                       head_skip;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign in_op   = opcode_t'(s_axis_tuser);
  assign in_val  = $signed(s_axis_tdata[SAMPLE_W-1:0]);
  assign in_idx  = s_axis_tdata[28:24];

  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !out_valid || m_axis_tready;

  always_comb begin
    if (feature_count == '0) begin
      lanes = IDX_W'(1);
    end else if (feature_count > FC_W'(MAX_FEATURES)) begin
      lanes = IDX_W'(MAX_FEATURES);
    end else begin
      lanes = feature_count;
    end
  end

  assign head_sample = $signed(ring[0].sample);
  assign next_sample = $signed(ring[1].sample);
  assign head_weight = $signed(ring[0].weight);
  assign head_gsum   = $signed(ring[0].gsum);
  assign head_active = hop < lanes;
  assign head_skip   = (hop != BIAS_IDX) && !head_active;
  assign src_sum     = (hop == BIAS_IDX) ? bias_gsum : head_gsum;
  assign src_weight  = (hop == BIAS_IDX) ? bias_value : head_weight;
  assign gsum_new    = sat48(head_gsum + ((prod + 56'sd32768) >>> 16));

  // rounding offset folded in: floor((m + d/2) / d) with d = count * 2^16
  assign mag_sum = {pp_hi, 24'd0} + {24'd0, pp_lo} + {40'd0, batch_count, 15'd0};
  assign den     = (batch_count == '0) ? BC_W'(1) : batch_count;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_FEATURES; gi++) begin : g_ring
      cell_t din;
      logic  ld_sample;
      logic  ld_weight;
      if (gi == MAX_FEATURES - 1) begin : g_tail
        assign din = tail_in;
      end else begin : g_mid
        assign din = ring[gi+1];
      end
      assign ld_sample = in_fire && (in_op == OP_FEATURE) && (feature_position < lanes)
                         && (feature_position == IDX_W'(gi));
      assign ld_weight = in_fire && (in_op == OP_LOAD) && (in_idx == IDX_W'(gi));
      mbsgd_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift      (shift),
        .ld_sample  (ld_sample),
        .ld_weight  (ld_weight),
        .load_value (in_val),
        .din        (din),
        .dout       (ring[gi])
      );
    end
  endgenerate

  mbsgd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mag_sum[63:16]),
    .den   (den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && (in_op == OP_TRAIN || in_op == OP_EVAL)) begin
          state_next = ST_DOT;
        end
      end
      ST_DOT:       if (hop == LAST_HOP) state_next = ST_DOT_FIN;
      ST_DOT_FIN:   state_next = ST_PRED;
      ST_PRED:      state_next = ST_ERR;
      ST_ERR:       state_next = ST_SQ;
      ST_SQ:        state_next = ST_EMIT_PRED;
      ST_EMIT_PRED: begin
        if (out_free) begin
          state_next = (op == OP_EVAL) ? ST_IDLE : ST_G_PRIME;
        end
      end
      ST_G_PRIME:   state_next = ST_G_WALK;
      ST_G_WALK:    if (hop == LAST_HOP) state_next = ST_G_END;
      ST_G_END:     state_next = eob ? ST_U_HEAD : ST_IDLE;
      ST_U_HEAD:    if (!head_skip) state_next = ST_U_MUL;
      ST_U_MUL:     state_next = ST_U_SUM;
      ST_U_SUM:     state_next = ST_U_DIV;
      ST_U_DIV:     if (div_done) state_next = ST_U_APPLY;
      ST_U_APPLY:   state_next = ST_U_EMIT;
      ST_U_EMIT: begin
        if (out_free) begin
          state_next = (hop == BIAS_IDX) ? ST_IDLE : ST_U_HEAD;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    shift     = 1'b0;
    tail_in   = ring[0];
    div_start = 1'b0;
    case (state)
      ST_DOT: shift = 1'b1;
      ST_G_WALK: begin
        shift = 1'b1;
        if (head_active) tail_in.gsum = gsum_new;
      end
      ST_U_HEAD: begin
        if (head_skip) begin
          shift        = 1'b1;
          tail_in.gsum = '0;
        end
      end
      ST_U_SUM: div_start = 1'b1;
      ST_U_EMIT: begin
        if (out_free && hop != BIAS_IDX) begin
          shift          = 1'b1;
          tail_in.weight = new_weight;
          tail_in.gsum   = '0;
        end
      end
      default: shift = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_rate     <= LR_W'(66);
      feature_count <= FC_W'(13);
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_STEP_RATE:     step_rate     <= cfg_data;
        REG_FEATURE_COUNT: feature_count <= cfg_data[FC_W-1:0];
        default:           step_rate     <= step_rate;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_position <= '0;
      bias_value       <= '0;
      bias_gsum        <= '0;
      batch_count      <= '0;
      hop              <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_op)
              OP_FEATURE: begin
                if (feature_position < lanes) feature_position <= feature_position + 1'b1;
              end
              OP_LOAD: begin
                if (in_idx == BIAS_IDX) begin
                  bias_value <= {{(WEIGHT_W - SAMPLE_W){in_val[SAMPLE_W-1]}}, in_val};
                end
              end
              default: begin
                feature_position <= '0;
                hop              <= '0;
              end
            endcase
          end
        end
        ST_DOT, ST_G_WALK: hop <= hop + 1'b1;
        ST_G_PRIME:        hop <= '0;
        ST_G_END: begin
          bias_gsum <= sat48(bias_gsum + err);
          if (batch_count < BC_W'(MAX_BATCH)) batch_count <= batch_count + 1'b1;
          hop <= '0;
        end
        ST_U_HEAD: if (head_skip) hop <= hop + 1'b1;
        ST_U_EMIT: begin
          if (out_free) begin
            if (hop == BIAS_IDX) begin
              bias_value  <= new_weight;
              bias_gsum   <= '0;
              batch_count <= '0;
            end else begin
              hop <= hop + 1'b1;
            end
          end
        end
        default: hop <= hop;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op     <= in_op;
        eob    <= s_axis_tlast;
        target <= in_val;
        prod   <= '0;
        acc    <= $signed({{13{bias_value[WEIGHT_W-1]}}, bias_value, 16'd0});
      end
      ST_DOT: begin
        prod <= head_active ? 56'(head_weight * head_sample) : '0;
        acc  <= acc + prod;
      end
      ST_DOT_FIN: acc <= acc + prod;
      ST_PRED:    pred <= sat32((acc + 61'sd32768) >>> 16);
      ST_ERR:     err <= sat32(pred - target);
      ST_SQ:      sq_raw <= err * err;
      ST_G_PRIME: prod <= 56'(err * head_sample);
      ST_G_WALK:  prod <= 56'(err * next_sample);
      ST_U_HEAD: begin
        neg <= src_sum[SUM_W-1];
        mag <= src_sum[SUM_W-1] ? SUM_W'(-src_sum) : src_sum;
      end
      ST_U_MUL: begin
        pp_hi <= step_rate * mag[SUM_W-1:24];
        pp_lo <= step_rate * mag[23:0];
      end
      ST_U_APPLY: begin
        new_weight <= neg ? sat32(src_weight + $signed({16'd0, quot}))
                          : sat32(src_weight - $signed({16'd0, quot}));
      end
      default: acc <= acc;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT_PRED && out_free) begin
      out_valid <= 1'b1;
    end else if (state == ST_U_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT_PRED && out_free) begin
      out_kind  <= 1'b0;
      out_value <= pred;
      out_err   <= err;
      out_sq    <= (|sq_raw[63:SQ_W]) ? '1 : sq_raw[SQ_W-1:0];
      out_index <= '0;
      out_last  <= !((op == OP_TRAIN) && eob);
    end else if (state == ST_U_EMIT && out_free) begin
      out_kind  <= 1'b1;
      out_value <= new_weight;
      out_err   <= '0;
      out_sq    <= '0;
      out_index <= hop;
      out_last  <= (hop == BIAS_IDX);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {3'd0, out_index, out_sq, out_err, out_value};

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_hop_range: assert property (@(posedge clk) disable iff (rst)
    hop <= BIAS_IDX)
    else $error("ring hop counter out of range");

  a_fpos_range: assert property (@(posedge clk) disable iff (rst)
    feature_position <= IDX_W'(MAX_FEATURES))
    else $error("feature position beyond buffer");

  a_walk_ends_home: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DOT && hop == LAST_HOP) |=> state == ST_DOT_FIN && hop == BIAS_IDX)
    else $error("dot product walk did not complete a full turn");

endmodule
